/* rtl/core/multi_ant_grid_automaton_macros.svh */
// assertion helpers for the rtl top level
`ifndef MULTI_ANT_GRID_AUTOMATON_MACROS_SVH
`define MULTI_ANT_GRID_AUTOMATON_MACROS_SVH

// same-cycle implication, checked out of reset
`define MAG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// next-cycle implication, checked out of reset
`define MAG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

/* rtl/core/mag_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package mag_pkg;

  localparam int MAX_ANTS    = 16;
  localparam int GRID_MAX_W  = 512;
  localparam int GRID_MAX_H  = 512;

  localparam int X_W         = $clog2(GRID_MAX_W);
  localparam int Y_W         = $clog2(GRID_MAX_H);
  localparam int SIZE_W      = $clog2(GRID_MAX_W + 1);
  localparam int DIR_W       = 2;
  localparam int ANT_IDX_W   = $clog2(MAX_ANTS);
  localparam int COUNT_W     = $clog2(MAX_ANTS + 1);
  localparam int CFG_W       = 10;
  localparam int CFG_IDX_W   = 1;

  // cell store: 64 cells per word, word address is {y, x upper bits}
  localparam int CELL_WORD_W = 64;
  localparam int CELL_OFS_W  = $clog2(CELL_WORD_W);
  localparam int CELL_ADDR_W = Y_W + X_W - CELL_OFS_W;
  localparam int CELL_DEPTH  = 2 ** CELL_ADDR_W;

  localparam logic       FUNC_TICK  = 1'b0;
  localparam logic       FUNC_SPAWN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

  localparam logic [DIR_W-1:0] DIR_Y_PLUS  = 2'd0;
  localparam logic [DIR_W-1:0] DIR_X_PLUS  = 2'd1;
  localparam logic [DIR_W-1:0] DIR_Y_MINUS = 2'd2;
  localparam logic [DIR_W-1:0] DIR_X_MINUS = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SPAWN,
    ST_ANT_RD,
    ST_ANT_CHK,
    ST_MOD,
    ST_CELL_RD,
    ST_EXEC
  } state_t;

  typedef struct packed {
    logic [X_W-1:0]   x;
    logic [Y_W-1:0]   y;
    logic [DIR_W-1:0] dir;
  } ant_rec_t;

  typedef struct packed {
    logic                 rd_en;
    logic                 wr_en;
    logic [ANT_IDX_W-1:0] rd_addr;
    logic [ANT_IDX_W-1:0] wr_addr;
    ant_rec_t             wdata;
  } ant_req_t;

  typedef struct packed {
    logic                   rd_en;
    logic                   wr_en;
    logic [CELL_ADDR_W-1:0] addr;
    logic [CELL_WORD_W-1:0] wdata;
  } cell_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_stat_t;

endpackage
`default_nettype wire

/* rtl/core/mag_cell_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
module mag_cell_mem
  import mag_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire cell_req_t              req,
  output logic [CELL_WORD_W-1:0]      rdata,
  output logic                        busy
);

  logic [CELL_WORD_W-1:0] mem [CELL_DEPTH];
  logic [CELL_ADDR_W-1:0] clr_addr_r, clr_addr_nxt;
  logic                   clearing_r, clearing_nxt;
  logic [CELL_WORD_W-1:0] rdata_r;

  // clearing pass after reset, one word a cycle
  always_comb begin
    clr_addr_nxt = clr_addr_r;
    clearing_nxt = clearing_r;
    if (clearing_r) begin
      clr_addr_nxt = clr_addr_r + CELL_ADDR_W'(1);
      if (clr_addr_r == CELL_ADDR_W'(CELL_DEPTH - 1)) begin
        clearing_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      clearing_r <= 1'b1;
    end else begin
      clr_addr_r <= clr_addr_nxt;
      clearing_r <= clearing_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_addr_r] <= '0;
    end else if (req.wr_en) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.addr];
    end
  end

  assign rdata = rdata_r;
  assign busy  = clearing_r;

endmodule
`default_nettype wire

/* rtl/core/mag_ant_mem.sv */
`timescale 1ns / 1ps
`default_nettype none
module mag_ant_mem
  import mag_pkg::*;
(
  input  wire logic     clk,
  input  wire ant_req_t req,
  output ant_rec_t      rdata
);

  ant_rec_t mem [MAX_ANTS];
  ant_rec_t rdata_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wdata;
    end
    if (req.rd_en) begin
      rdata_r <= mem[req.rd_addr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

/* rtl/core/mag_mod.sv */
`timescale 1ns / 1ps
`default_nettype none
module mag_mod
  import mag_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [X_W-1:0]    dvd_x,
  input  wire logic [Y_W-1:0]    dvd_y,
  input  wire logic [SIZE_W-1:0] div_x,
  input  wire logic [SIZE_W-1:0] div_y,
  output logic [X_W-1:0]         rem_x,
  output logic [Y_W-1:0]         rem_y,
  output mod_stat_t              stat
);

  localparam int CNT_W = $clog2(X_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [X_W-1:0]    dx_r, dx_nxt;
  logic [Y_W-1:0]    dy_r, dy_nxt;
  logic [SIZE_W-1:0] rx_r, rx_nxt;
  logic [SIZE_W-1:0] ry_r, ry_nxt;
  logic [SIZE_W-1:0] sx, sy;

  // restoring remainder, one dividend bit per cycle on both lanes
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dx_nxt   = dx_r;
    dy_nxt   = dy_r;
    rx_nxt   = rx_r;
    ry_nxt   = ry_r;
    sx       = {rx_r[SIZE_W-2:0], dx_r[X_W-1]};
    sy       = {ry_r[SIZE_W-2:0], dy_r[Y_W-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(X_W);
      dx_nxt   = dvd_x;
      dy_nxt   = dvd_y;
      rx_nxt   = '0;
      ry_nxt   = '0;
    end else if (busy_r) begin
      rx_nxt  = (sx >= div_x) ? sx - div_x : sx;
      ry_nxt  = (sy >= div_y) ? sy - div_y : sy;
      dx_nxt  = {dx_r[X_W-2:0], 1'b0};
      dy_nxt  = {dy_r[Y_W-2:0], 1'b0};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
    rx_r <= rx_nxt;
    ry_r <= ry_nxt;
  end

  assign rem_x     = rx_r[X_W-1:0];
  assign rem_y     = ry_r[Y_W-1:0];
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
`default_nettype wire

/* rtl/core/multi_ant_grid_automaton.sv */
// channel | direction | handshake            | payload
// in_     | input     | in_valid / in_stall   | func, spawn_x, spawn_y, spawn_dir
// out_    | output    | out_valid / out_stall | ant_index, cell and ant fields, spawn_accepted, last
// cfg_    | input     | cfg_wr_en             | cfg_addr, cfg_wdata
//
// spawn: ST_SPAWN loads the result once the output register is free,
//   then the sequencer returns to idle
// tick: per ant: ant table read, cell word read, modify and write back; if the grid
//   was shrunk under the ant, the bit-serial remainder unit runs before the cell read
// reset: the 4096-word cell store clears one 64-cell word a cycle, in_stall high
// out_stall holds the write-back and spawn steps; one item is worked at a time
`timescale 1ns / 1ps
`default_nettype none
`include "multi_ant_grid_automaton_macros.svh"
module multi_ant_grid_automaton
  import mag_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,

  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_func,
  input  wire logic [X_W-1:0]       in_spawn_x,
  input  wire logic [Y_W-1:0]       in_spawn_y,
  input  wire logic [DIR_W-1:0]     in_spawn_dir,

  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [ANT_IDX_W-1:0]      out_ant_index,
  output logic [X_W-1:0]            out_cell_x,
  output logic [Y_W-1:0]            out_cell_y,
  output logic                      out_cell_color,
  output logic [X_W-1:0]            out_new_x,
  output logic [Y_W-1:0]            out_new_y,
  output logic [DIR_W-1:0]          out_new_dir,
  output logic                      out_spawn_accepted,
  output logic                      out_last,

  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_addr,
  input  wire logic [CFG_W-1:0]     cfg_wdata
);

  // configuration
  logic [CFG_W-1:0]  width_r, width_nxt;
  logic [CFG_W-1:0]  height_r, height_nxt;
  logic [SIZE_W-1:0] w_eff, h_eff;

  // sequencer
  state_t               state_r, state_nxt;
  logic [COUNT_W-1:0]   count_r, count_nxt;
  logic [ANT_IDX_W-1:0] idx_r, idx_nxt;
  logic [X_W-1:0]       cur_x_r, cur_x_nxt;
  logic [Y_W-1:0]       cur_y_r, cur_y_nxt;
  logic [DIR_W-1:0]     cur_d_r, cur_d_nxt;
  logic [X_W-1:0]       sp_x_r, sp_x_nxt;
  logic [Y_W-1:0]       sp_y_r, sp_y_nxt;
  logic [DIR_W-1:0]     sp_d_r, sp_d_nxt;

  // memories and remainder unit
  cell_req_t              cell_req;
  logic [CELL_WORD_W-1:0] cell_rdata;
  logic                   cell_busy;
  ant_req_t               ant_req;
  ant_rec_t               ant_rdata;
  logic                   mod_start;
  logic [X_W-1:0]         mod_rem_x;
  logic [Y_W-1:0]         mod_rem_y;
  mod_stat_t              mod_stat;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic                 out_load;
  logic                 out_free;
  logic [ANT_IDX_W-1:0] o_idx_r, o_idx_nxt;
  logic [X_W-1:0]       o_cx_r, o_cx_nxt;
  logic [Y_W-1:0]       o_cy_r, o_cy_nxt;
  logic                 o_col_r, o_col_nxt;
  logic [X_W-1:0]       o_nx_r, o_nx_nxt;
  logic [Y_W-1:0]       o_ny_r, o_ny_nxt;
  logic [DIR_W-1:0]     o_nd_r, o_nd_nxt;
  logic                 o_acc_r, o_acc_nxt;
  logic                 o_last_r, o_last_nxt;

  // step datapath
  logic [CELL_OFS_W-1:0] ofs;
  logic                  old_color;
  logic [DIR_W-1:0]      step_d;
  logic [X_W-1:0]        step_x;
  logic [Y_W-1:0]        step_y;
  logic [SIZE_W-1:0]     x_inc, y_inc;
  logic                  ant_last;
  logic                  spawn_ok;
  logic                  in_accept;

  // register writes, to be made only while idle; the block itself does not enforce it
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_IDX_WIDTH:  width_nxt  = cfg_wdata;
        CFG_IDX_HEIGHT: height_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  // zero acts as one, oversize clamps to the grid maximum
  always_comb begin
    if (width_r == '0) begin
      w_eff = SIZE_W'(1);
    end else if (width_r > CFG_W'(GRID_MAX_W)) begin
      w_eff = SIZE_W'(GRID_MAX_W);
    end else begin
      w_eff = SIZE_W'(width_r);
    end
    if (height_r == '0) begin
      h_eff = SIZE_W'(1);
    end else if (height_r > CFG_W'(GRID_MAX_H)) begin
      h_eff = SIZE_W'(GRID_MAX_H);
    end else begin
      h_eff = SIZE_W'(height_r);
    end
  end

  assign in_stall  = (state_r != ST_IDLE) || cell_busy;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  // one ant step: turn on the old color, flip, move with wraparound
  always_comb begin
    ofs       = cur_x_r[CELL_OFS_W-1:0];
    old_color = cell_rdata[ofs];
    step_d    = old_color ? cur_d_r - DIR_W'(1) : cur_d_r + DIR_W'(1);
    x_inc     = SIZE_W'(cur_x_r) + SIZE_W'(1);
    y_inc     = SIZE_W'(cur_y_r) + SIZE_W'(1);
    step_x    = cur_x_r;
    step_y    = cur_y_r;
    case (step_d)
      DIR_Y_PLUS:  step_y = (y_inc == h_eff) ? '0 : y_inc[Y_W-1:0];
      DIR_X_PLUS:  step_x = (x_inc == w_eff) ? '0 : x_inc[X_W-1:0];
      DIR_Y_MINUS: begin
        step_y = (cur_y_r == '0) ? Y_W'(h_eff - SIZE_W'(1)) : cur_y_r - Y_W'(1);
      end
      default: begin
        step_x = (cur_x_r == '0) ? X_W'(w_eff - SIZE_W'(1)) : cur_x_r - X_W'(1);
      end
    endcase
    ant_last = (COUNT_W'(idx_r) + COUNT_W'(1)) == count_r;
    spawn_ok = (SIZE_W'(sp_x_r) < w_eff) && (SIZE_W'(sp_y_r) < h_eff)
               && (count_r < COUNT_W'(MAX_ANTS));
  end

  // sequencer: next state, memory requests, result loading
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    cur_d_nxt  = cur_d_r;
    sp_x_nxt   = sp_x_r;
    sp_y_nxt   = sp_y_r;
    sp_d_nxt   = sp_d_r;
    mod_start  = 1'b0;
    out_load   = 1'b0;
    o_idx_nxt  = o_idx_r;
    o_cx_nxt   = o_cx_r;
    o_cy_nxt   = o_cy_r;
    o_col_nxt  = o_col_r;
    o_nx_nxt   = o_nx_r;
    o_ny_nxt   = o_ny_r;
    o_nd_nxt   = o_nd_r;
    o_acc_nxt  = o_acc_r;
    o_last_nxt = o_last_r;

    cell_req.rd_en   = 1'b0;
    cell_req.wr_en   = 1'b0;
    cell_req.addr    = {cur_y_r, cur_x_r[X_W-1:CELL_OFS_W]};
    cell_req.wdata   = cell_rdata ^ (CELL_WORD_W'(1) << ofs);
    ant_req.rd_en    = 1'b0;
    ant_req.wr_en    = 1'b0;
    ant_req.rd_addr  = idx_r;
    ant_req.wr_addr  = idx_r;
    ant_req.wdata    = '{x: step_x, y: step_y, dir: step_d};

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          sp_x_nxt = in_spawn_x;
          sp_y_nxt = in_spawn_y;
          sp_d_nxt = in_spawn_dir;
          idx_nxt  = '0;
          if (in_func == FUNC_SPAWN) begin
            state_nxt = ST_SPAWN;
          end else if (count_r != '0) begin
            state_nxt = ST_ANT_RD;
          end
        end
      end
      ST_SPAWN: begin
        if (out_free) begin
          out_load   = 1'b1;
          o_cx_nxt   = '0;
          o_cy_nxt   = '0;
          o_col_nxt  = 1'b0;
          o_last_nxt = 1'b1;
          o_acc_nxt  = spawn_ok;
          if (spawn_ok) begin
            ant_req.wr_en   = 1'b1;
            ant_req.wr_addr = count_r[ANT_IDX_W-1:0];
            ant_req.wdata   = '{x: sp_x_r, y: sp_y_r, dir: sp_d_r};
            count_nxt       = count_r + COUNT_W'(1);
            o_idx_nxt       = count_r[ANT_IDX_W-1:0];
            o_nx_nxt        = sp_x_r;
            o_ny_nxt        = sp_y_r;
            o_nd_nxt        = sp_d_r;
          end else begin
            o_idx_nxt = '0;
            o_nx_nxt  = '0;
            o_ny_nxt  = '0;
            o_nd_nxt  = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      ST_ANT_RD: begin
        ant_req.rd_en = 1'b1;
        state_nxt     = ST_ANT_CHK;
      end
      ST_ANT_CHK: begin
        cur_x_nxt = ant_rdata.x;
        cur_y_nxt = ant_rdata.y;
        cur_d_nxt = ant_rdata.dir;
        // grid shrunk under this ant: reduce its position first
        if ((SIZE_W'(ant_rdata.x) >= w_eff) || (SIZE_W'(ant_rdata.y) >= h_eff)) begin
          mod_start = 1'b1;
          state_nxt = ST_MOD;
        end else begin
          state_nxt = ST_CELL_RD;
        end
      end
      ST_MOD: begin
        if (mod_stat.done) begin
          cur_x_nxt = mod_rem_x;
          cur_y_nxt = mod_rem_y;
          state_nxt = ST_CELL_RD;
        end
      end
      ST_CELL_RD: begin
        cell_req.rd_en = 1'b1;
        state_nxt      = ST_EXEC;
      end
      ST_EXEC: begin
        if (out_free) begin
          cell_req.wr_en = 1'b1;
          ant_req.wr_en  = 1'b1;
          out_load       = 1'b1;
          o_idx_nxt      = idx_r;
          o_cx_nxt       = cur_x_r;
          o_cy_nxt       = cur_y_r;
          o_col_nxt      = !old_color;
          o_nx_nxt       = step_x;
          o_ny_nxt       = step_y;
          o_nd_nxt       = step_d;
          o_acc_nxt      = 1'b0;
          o_last_nxt     = ant_last;
          if (ant_last) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r + ANT_IDX_W'(1);
            state_nxt = ST_ANT_RD;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    out_valid_nxt = out_load ? 1'b1 : (out_stall ? out_valid_r : 1'b0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      width_r     <= CFG_W'(500);
      height_r    <= CFG_W'(500);
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
      width_r     <= width_nxt;
      height_r    <= height_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    cur_x_r  <= cur_x_nxt;
    cur_y_r  <= cur_y_nxt;
    cur_d_r  <= cur_d_nxt;
    sp_x_r   <= sp_x_nxt;
    sp_y_r   <= sp_y_nxt;
    sp_d_r   <= sp_d_nxt;
    o_idx_r  <= o_idx_nxt;
    o_cx_r   <= o_cx_nxt;
    o_cy_r   <= o_cy_nxt;
    o_col_r  <= o_col_nxt;
    o_nx_r   <= o_nx_nxt;
    o_ny_r   <= o_ny_nxt;
    o_nd_r   <= o_nd_nxt;
    o_acc_r  <= o_acc_nxt;
    o_last_r <= o_last_nxt;
  end

  mag_cell_mem u_cell_mem (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (cell_req),
    .rdata (cell_rdata),
    .busy  (cell_busy)
  );

  mag_ant_mem u_ant_mem (
    .clk   (clk),
    .req   (ant_req),
    .rdata (ant_rdata)
  );

  mag_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .dvd_x (ant_rdata.x),
    .dvd_y (ant_rdata.y),
    .div_x (w_eff),
    .div_y (h_eff),
    .rem_x (mod_rem_x),
    .rem_y (mod_rem_y),
    .stat  (mod_stat)
  );

  assign out_valid          = out_valid_r;
  assign out_ant_index      = o_idx_r;
  assign out_cell_x         = o_cx_r;
  assign out_cell_y         = o_cy_r;
  assign out_cell_color     = o_col_r;
  assign out_new_x          = o_nx_r;
  assign out_new_y          = o_ny_r;
  assign out_new_dir        = o_nd_r;
  assign out_spawn_accepted = o_acc_r;
  assign out_last           = o_last_r;

  // no transaction is taken while the cell store is being cleared
  `MAG_ASSERT_NOW(a_no_accept_clearing, cell_busy, in_stall)
  // ant table never grows past its depth
  `MAG_ASSERT_NOW(a_count_bound, 1'b1, count_r <= COUNT_W'(MAX_ANTS))
  // remainder unit runs only while the sequencer waits on it
  `MAG_ASSERT_NOW(a_mod_owned, mod_stat.busy || mod_stat.done, state_r == ST_MOD)
  // the final result of an item returns the sequencer to idle
  `MAG_ASSERT_NEXT(a_last_to_idle, out_load && o_last_nxt, state_r == ST_IDLE)

endmodule
`default_nettype wire

/* bench/tb_multi_ant_grid_automaton.sv */
`timescale 1ns / 1ps
module tb_multi_ant_grid_automaton;
  import mag_pkg::*;

  // run shape
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 64;   // covers a tick with an empty ant table
  localparam int LONG_HOLD     = 400;  // receiver hold-off that backs up the block
  localparam int PHASES        = 7;
  localparam int PHASE_ITEMS   = 51;
  localparam int RANDOM_PHASE  = 5;    // grid size drawn at random
  localparam int HOLD_PHASE    = 3;    // phase with the long receiver hold-off
  localparam int DRAIN_PHASE   = 4;    // phase with a mid-phase pause of the sender

  // one result transaction
  typedef struct packed {
    logic [ANT_IDX_W-1:0] ant_index;
    logic [X_W-1:0]       cell_x;
    logic [Y_W-1:0]       cell_y;
    logic                 cell_color;
    logic [X_W-1:0]       new_x;
    logic [Y_W-1:0]       new_y;
    logic [DIR_W-1:0]     new_dir;
    logic                 spawn_accepted;
    logic                 last;
  } ant_result_t;

  // one row of the directed table, with a typed-in result where it is obvious
  typedef struct packed {
    logic             func;
    logic [X_W-1:0]   x;
    logic [Y_W-1:0]   y;
    logic [DIR_W-1:0] dir;
    logic             typed;
    ant_result_t      exp;
  } stim_row_t;

  // a spawn that lands in the given slot
  function automatic ant_result_t spawn_taken(input int slot, input int x, input int y,
                                              input logic [DIR_W-1:0] d);
    ant_result_t r;
    r = '0;
    r.ant_index      = ANT_IDX_W'(slot);
    r.new_x          = X_W'(x);
    r.new_y          = Y_W'(y);
    r.new_dir        = d;
    r.spawn_accepted = 1'b1;
    r.last           = 1'b1;
    return r;
  endfunction

  // refused spawn: every field zero except last
  localparam ant_result_t REFUSED =
    '{4'd0, 9'd0, 9'd0, 1'b0, 9'd0, 9'd0, DIR_Y_PLUS, 1'b0, 1'b1};
  localparam ant_result_t NOT_TYPED = '0;

  // directed part, all at the reset grid size of 500 x 500
  localparam int DIRECTED_N = 15;
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_N] = '{
    // tick on an empty table gives no result
    '{FUNC_TICK,  9'd0,   9'd0,   DIR_Y_PLUS,  1'b0, NOT_TYPED},
    // last column and row in use, first ant
    '{FUNC_SPAWN, 9'd499, 9'd499, DIR_X_MINUS, 1'b1, spawn_taken(0, 499, 499, DIR_X_MINUS)},
    // x just past the grid, y just past the grid, both at the field maximum
    '{FUNC_SPAWN, 9'd500, 9'd0,   DIR_Y_PLUS,  1'b1, REFUSED},
    '{FUNC_SPAWN, 9'd0,   9'd500, DIR_X_PLUS,  1'b1, REFUSED},
    '{FUNC_SPAWN, 9'd511, 9'd511, DIR_X_MINUS, 1'b1, REFUSED},
    '{FUNC_SPAWN, 9'd0,   9'd0,   DIR_Y_PLUS,  1'b1, spawn_taken(1, 0, 0, DIR_Y_PLUS)},
    // first ant wraps from the top row back to row zero
    '{FUNC_TICK,  9'd0,   9'd0,   DIR_Y_PLUS,  1'b0, NOT_TYPED},
    '{FUNC_SPAWN, 9'd0,   9'd0,   DIR_X_PLUS,  1'b1, spawn_taken(2, 0, 0, DIR_X_PLUS)},
    '{FUNC_SPAWN, 9'd0,   9'd499, DIR_Y_MINUS, 1'b1, spawn_taken(3, 0, 499, DIR_Y_MINUS)},
    '{FUNC_SPAWN, 9'd256, 9'd170, DIR_X_MINUS, 1'b1, spawn_taken(4, 256, 170, DIR_X_MINUS)},
    // ants meet on painted cells, both turn directions
    '{FUNC_TICK,  9'd0,   9'd0,   DIR_Y_PLUS,  1'b0, NOT_TYPED},
    '{FUNC_TICK,  9'd0,   9'd0,   DIR_Y_PLUS,  1'b0, NOT_TYPED},
    '{FUNC_SPAWN, 9'd499, 9'd0,   DIR_Y_MINUS, 1'b1, spawn_taken(5, 499, 0, DIR_Y_MINUS)},
    '{FUNC_TICK,  9'd0,   9'd0,   DIR_Y_PLUS,  1'b0, NOT_TYPED},
    '{FUNC_TICK,  9'd0,   9'd0,   DIR_Y_PLUS,  1'b0, NOT_TYPED}
  };

  // grid sizes written per phase: max, shrink, zero, above range, thin strips
  localparam logic [CFG_W-1:0] PHASE_COLS [PHASES] =
    '{10'd512, 10'd7, 10'd0, 10'd1023, 10'd2, 10'd0, 10'd40};
  localparam logic [CFG_W-1:0] PHASE_ROWS [PHASES] =
    '{10'd512, 10'd4, 10'd0, 10'd700, 10'd511, 10'd0, 10'd1};

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_func = FUNC_TICK;
  logic [X_W-1:0]       in_spawn_x = '0;
  logic [Y_W-1:0]       in_spawn_y = '0;
  logic [DIR_W-1:0]     in_spawn_dir = DIR_Y_PLUS;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ANT_IDX_W-1:0] out_ant_index;
  logic [X_W-1:0]       out_cell_x;
  logic [Y_W-1:0]       out_cell_y;
  logic                 out_cell_color;
  logic [X_W-1:0]       out_new_x;
  logic [Y_W-1:0]       out_new_y;
  logic [DIR_W-1:0]     out_new_dir;
  logic                 out_spawn_accepted;
  logic                 out_last;

  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_addr = CFG_IDX_WIDTH;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  multi_ant_grid_automaton dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_spawn_x         (in_spawn_x),
    .in_spawn_y         (in_spawn_y),
    .in_spawn_dir       (in_spawn_dir),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_ant_index      (out_ant_index),
    .out_cell_x         (out_cell_x),
    .out_cell_y         (out_cell_y),
    .out_cell_color     (out_cell_color),
    .out_new_x          (out_new_x),
    .out_new_y          (out_new_y),
    .out_new_dir        (out_new_dir),
    .out_spawn_accepted (out_spawn_accepted),
    .out_last           (out_last),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mirror of the block: grid, ant table and size registers
  bit               cell_grid [GRID_MAX_H][GRID_MAX_W];
  int               ant_col [MAX_ANTS];
  int               ant_row [MAX_ANTS];
  logic [DIR_W-1:0] ant_dir [MAX_ANTS];
  int               ant_total = 0;
  logic [CFG_W-1:0] cols_reg = 10'd500;
  logic [CFG_W-1:0] rows_reg = 10'd500;

  // results still owed by the block, oldest first
  ant_result_t pending_results [$];

  int mismatches = 0;
  int results_checked = 0;
  int ticks_sent = 0;
  int spawns_taken = 0;
  int spawns_refused = 0;
  int settings_used = 1;
  int cycle_count = 0;
  int burst_left = 0;
  int hold_requests = 0;

  // size in use: zero acts as one, anything past the grid acts as the grid
  function automatic int grid_extent(input logic [CFG_W-1:0] value, input int limit);
    if (value == '0) return 1;
    if (int'(value) > limit) return limit;
    return int'(value);
  endfunction

  // appends one expected result behind those already owed
  task automatic owe_result(input ant_result_t r);
    pending_results.insert(pending_results.size(), r);
  endtask

  // works out the results of one accepted input transaction
  task automatic advance_colony(input logic f, input logic [X_W-1:0] sx,
                                input logic [Y_W-1:0] sy, input logic [DIR_W-1:0] sd);
    int w;
    int h;
    int x;
    int y;
    int nx;
    int ny;
    logic [DIR_W-1:0] d;
    logic paint;
    ant_result_t r;
    w = grid_extent(cols_reg, GRID_MAX_W);
    h = grid_extent(rows_reg, GRID_MAX_H);
    if (f == FUNC_SPAWN) begin
      r = REFUSED;
      // both limits are checked, plus room in the table
      if (int'(sx) < w && int'(sy) < h && ant_total < MAX_ANTS) begin
        ant_col[ant_total] = int'(sx);
        ant_row[ant_total] = int'(sy);
        ant_dir[ant_total] = sd;
        r = spawn_taken(ant_total, int'(sx), int'(sy), sd);
        ant_total++;
        spawns_taken++;
      end else begin
        spawns_refused++;
      end
      owe_result(r);
    end else begin
      ticks_sent++;
      for (int i = 0; i < ant_total; i++) begin
        // grid may have shrunk under the ant since its last step
        x = ant_col[i] % w;
        y = ant_row[i] % h;
        d = ant_dir[i];
        paint = cell_grid[y][x];
        cell_grid[y][x] = ~paint;
        // white steps the direction code up by one, black steps it down by one
        d = paint ? d - 2'd1 : d + 2'd1;
        nx = x;
        ny = y;
        case (d)
          DIR_Y_PLUS:  ny = (y + 1 == h) ? 0 : y + 1;
          DIR_X_PLUS:  nx = (x + 1 == w) ? 0 : x + 1;
          DIR_Y_MINUS: ny = (y == 0) ? h - 1 : y - 1;
          default:     nx = (x == 0) ? w - 1 : x - 1;
        endcase
        ant_col[i] = nx;
        ant_row[i] = ny;
        ant_dir[i] = d;
        r                = '0;
        r.ant_index      = ANT_IDX_W'(i);
        r.cell_x         = X_W'(x);
        r.cell_y         = Y_W'(y);
        r.cell_color     = ~paint;
        r.new_x          = X_W'(nx);
        r.new_y          = Y_W'(ny);
        r.new_dir        = d;
        r.last           = (i == ant_total - 1);
        owe_result(r);
      end
    end
  endtask

  // one line per mismatch, and the count
  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] error: %s", $realtime, what);
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h expected %0h (result %0d)",
                                name, got, want, results_checked));
  endtask

  // offers one input transaction, in bursts with random gaps between them
  task automatic offer_item(input logic f, input logic [X_W-1:0] x,
                            input logic [Y_W-1:0] y, input logic [DIR_W-1:0] d);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid     <= 1'b1;
    in_func      <= f;
    in_spawn_x   <= x;
    in_spawn_y   <= y;
    in_spawn_dir <= d;
    @(posedge clk);
    // x on in_stall is not taken as acceptance
    while (in_stall !== 1'b0) @(posedge clk);
    advance_colony(f, x, y, d);
  endtask

  // sender pause until the block owes nothing, then a little extra for quiet work
  task automatic wait_for_results();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_grid_size(input logic [CFG_W-1:0] cols, input logic [CFG_W-1:0] rows);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= CFG_IDX_WIDTH;
    cfg_wdata <= cols;
    @(posedge clk);
    cfg_addr  <= CFG_IDX_HEIGHT;
    cfg_wdata <= rows;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    cols_reg = cols;
    rows_reg = rows;
    settings_used++;
  endtask

  // receiver: stall modes of random length, plus a long hold-off on request
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  int holds_served = 0;

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != hold_requests) begin
      holds_served <= holds_served + 1;
      hold_left    <= LONG_HOLD;
      out_stall    <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        mode_left  <= $urandom_range(5, 60);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 0);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // every accepted result transaction against the oldest expectation
  always @(posedge clk) begin : result_check
    ant_result_t want;
    if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result transaction with nothing expected");
      end else begin
        want = pending_results.pop_front();
        check_field("ant_index",      16'(out_ant_index),      16'(want.ant_index));
        check_field("cell_x",         16'(out_cell_x),         16'(want.cell_x));
        check_field("cell_y",         16'(out_cell_y),         16'(want.cell_y));
        check_field("cell_color",     16'(out_cell_color),     16'(want.cell_color));
        check_field("new_x",          16'(out_new_x),          16'(want.new_x));
        check_field("new_y",          16'(out_new_y),          16'(want.new_y));
        check_field("new_dir",        16'(out_new_dir),        16'(want.new_dir));
        check_field("spawn_accepted", 16'(out_spawn_accepted), 16'(want.spawn_accepted));
        check_field("last",           16'(out_last),           16'(want.last));
        results_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("multi_ant_grid_automaton: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    int w;
    int h;
    logic [CFG_W-1:0] cols;
    logic [CFG_W-1:0] rows;
    logic f;
    logic [X_W-1:0] x;
    logic [Y_W-1:0] y;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed rows; the grid clearing pass after reset shows up as in_stall
    for (int k = 0; k < DIRECTED_N; k++) begin
      offer_item(DIRECTED_ROWS[k].func, DIRECTED_ROWS[k].x, DIRECTED_ROWS[k].y,
                 DIRECTED_ROWS[k].dir);
      if (DIRECTED_ROWS[k].typed) begin
        pending_results[pending_results.size() - 1] = DIRECTED_ROWS[k].exp;
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      // grid size only changes with the block idle
      in_valid <= 1'b0;
      burst_left = 0;
      wait_for_results();
      cols = (p == RANDOM_PHASE) ? CFG_W'($urandom_range(1, 1023)) : PHASE_COLS[p];
      rows = (p == RANDOM_PHASE) ? CFG_W'($urandom_range(1, 1023)) : PHASE_ROWS[p];
      write_grid_size(cols, rows);
      w = grid_extent(cols_reg, GRID_MAX_W);
      h = grid_extent(rows_reg, GRID_MAX_H);

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // receiver goes quiet for a long stretch while items keep coming
        if (p == HOLD_PHASE && n == 10) hold_requests <= hold_requests + 1;
        if (p == DRAIN_PHASE && n == 25) begin
          in_valid <= 1'b0;
          burst_left = 0;
          wait_for_results();
        end
        f = ($urandom_range(0, 9) < 4) ? FUNC_SPAWN : FUNC_TICK;
        // spawns mostly inside the grid in use, the rest anywhere in the field
        if ($urandom_range(0, 4) != 0) begin
          x = X_W'($urandom_range(0, w - 1));
          y = Y_W'($urandom_range(0, h - 1));
        end else begin
          x = X_W'($urandom);
          y = Y_W'($urandom);
        end
        offer_item(f, x, y, DIR_W'($urandom));
      end
    end

    in_valid <= 1'b0;
    wait_for_results();

    $display("ran %0d ticks and %0d spawns (%0d taken, %0d refused), %0d ants",
             ticks_sent, spawns_taken + spawns_refused, spawns_taken, spawns_refused,
             ant_total);
    $display("checked %0d result transactions over %0d grid sizes",
             results_checked, settings_used);
    if (mismatches == 0) begin
      $display("multi_ant_grid_automaton: match");
    end else begin
      $display("multi_ant_grid_automaton: mismatch");
    end
    $finish;
  end

endmodule

/* multi_ant_grid_automaton.f */
+incdir+rtl/core
rtl/core/mag_pkg.sv
rtl/core/mag_cell_mem.sv
rtl/core/mag_ant_mem.sv
rtl/core/mag_mod.sv
rtl/core/multi_ant_grid_automaton.sv
bench/tb_multi_ant_grid_automaton.sv
